// ===== sv/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg
// Types, constants and helpers shared by the subtractive generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

	localparam int VALUE_W     = 30;
	localparam int SEED_W      = 32;
	localparam int RING_LEN    = 55;
	localparam int LAG_TAP     = 31;
	localparam int FILL_STRIDE = 21;
	localparam int FILL_TAP    = (FILL_STRIDE * (RING_LEN - 1) - 1) % RING_LEN;
	localparam int WARM_STEPS  = 4 * RING_LEN;
	localparam int STEP_W      = 8;

	localparam logic [SEED_W-1:0]  MODULUS_S = 32'd1000000000;
	localparam logic [VALUE_W-1:0] MODULUS_V = 30'd1000000000;
	localparam logic [SEED_W-1:0]  SEED_BASE = 32'd161803398;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [SEED_W-1:0]  seed_t;
	typedef logic [STEP_W-1:0]  step_t;

	typedef struct packed {
		logic shift;
		logic fill;
	} ring_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_FILL   = 5'b00100,
		S_WARM   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	function automatic value_t sub_mod(input value_t a, input value_t b);
		value_t r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = a + (MODULUS_V - b);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/srg_req_if.sv =====
// ----------------------------------------------------------------------------
// srg_req_if
// Request channel: one transaction asks for one number.
// ----------------------------------------------------------------------------
`default_nettype none

interface srg_req_if;
	import srg_pkg::*;

	logic  valid;
	logic  ready;
	logic  reseed;
	seed_t seed;

	modport source (output valid, output reseed, output seed, input ready);
	modport sink (input valid, input reseed, input seed, output ready);
endinterface

`default_nettype wire

// ===== sv/srg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// srg_rsp_if
// Response channel: one transaction carries one number.
// ----------------------------------------------------------------------------
`default_nettype none

interface srg_rsp_if;
	import srg_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/subtractive_random_generator.sv =====
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Subtractive lagged generator, modulus 10^9, 55-entry table in a cell ring.
//
// Each req transaction asks for one number; rsp returns it as a numerator in
// units of 1e-9 in [0, 999999999]. The table lives in a ring of 55 cells that
// rotates by one on every draw, so the current and lagged entries sit at
// fixed taps and a draw is one subtract and one shift.
// A draw without seeding has its result registered, and it shows on rsp in the
// next cycle; draws sustain one per cycle while rsp does not stall.
// A transaction with reseed set, or the first one after reset, rebuilds the
// table: seed reduction, then fill, then warm-up and a final draw, during
// which req is not ready.
// Reset clears the control state and marks the block unseeded.
// When rsp stalls, the held result stays and one more draw may complete only
// as the held result is taken; req drops ready until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module subtractive_random_generator (
	input  wire       clk,
	input  wire       arst_n,
	srg_req_if.sink   req,
	srg_rsp_if.source rsp
);
	import srg_pkg::*;

	value_t    ring [RING_LEN];
	value_t    diff;
	value_t    fill_word;
	ring_ctl_t ctl;

	srg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.head      (ring[0]),
		.lag       (ring[LAG_TAP]),
		.diff      (diff),
		.fill_word (fill_word),
		.ctl       (ctl)
	);

	for (genvar k = 0; k < RING_LEN; k++) begin : g_cell
		localparam int STEP_SRC = (k + 1) % RING_LEN;
		localparam int FILL_SRC = (k + FILL_STRIDE) % RING_LEN;
		value_t d_step;
		value_t d_fill;

		assign d_step = (k == RING_LEN - 1) ? diff : ring[STEP_SRC];
		assign d_fill = (k == FILL_TAP) ? fill_word : ring[FILL_SRC];

		srg_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.d_step (d_step),
			.d_fill (d_fill),
			.q      (ring[k])
		);
	end
endmodule

`default_nettype wire

// ===== sv/srg_cell.sv =====
// ----------------------------------------------------------------------------
// srg_cell
// One table entry of the rotating ring; takes its step or fill neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_cell (
	input  wire                clk,
	input  srg_pkg::ring_ctl_t ctl,
	input  srg_pkg::value_t    d_step,
	input  srg_pkg::value_t    d_fill,
	output srg_pkg::value_t    q
);
	import srg_pkg::*;

	value_t value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= ctl.fill ? d_fill : d_step;
		end
	end

	assign q = value_q;
endmodule

`default_nettype wire

// ===== sv/srg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: seed reduction, table fill, warm-up, draws and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	srg_req_if.sink             req,
	srg_rsp_if.source           rsp,
	input  srg_pkg::value_t     head,
	input  srg_pkg::value_t     lag,
	output srg_pkg::value_t     diff,
	output srg_pkg::value_t     fill_word,
	output srg_pkg::ring_ctl_t  ctl
);
	import srg_pkg::*;

	state_t state_q;
	logic   seeded_q;
	step_t  step_q;
	logic   out_valid_q;
	value_t value_q;
	seed_t  cur_q;
	value_t w_q;
	value_t wprev_q;

	logic   slot_free;
	logic   accept;
	logic   need_seed;
	logic   draw_now;
	seed_t  seed_dist;

	always_comb begin
		slot_free = !out_valid_q || rsp.ready;
		req.ready = (state_q == S_IDLE) && slot_free;
		accept    = req.valid && req.ready;
		need_seed = req.reseed || !seeded_q;
		draw_now  = (accept && !need_seed) || ((state_q == S_FINISH) && slot_free);
		diff      = sub_mod(head, lag);
		ctl.shift = draw_now || (state_q == S_FILL) || (state_q == S_WARM);
		ctl.fill  = (state_q == S_FILL);
		fill_word = w_q;
		if (req.seed >= SEED_BASE) begin
			seed_dist = req.seed - SEED_BASE;
		end else begin
			seed_dist = SEED_BASE - req.seed;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (draw_now) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && need_seed) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (cur_q < MODULUS_S) begin
						state_q <= S_FILL;
						step_q  <= '0;
					end
				end
				S_FILL: begin
					if (step_q == STEP_W'(RING_LEN - 1)) begin
						state_q <= S_WARM;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_WARM: begin
					if (step_q == STEP_W'(WARM_STEPS - 1)) begin
						state_q  <= S_FINISH;
						seeded_q <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (draw_now) begin
			value_q <= diff;
		end
		if (accept && need_seed) begin
			cur_q <= seed_dist;
		end else if ((state_q == S_REDUCE) && (cur_q >= MODULUS_S)) begin
			cur_q <= cur_q - MODULUS_S;
		end
		if ((state_q == S_REDUCE) && (cur_q < MODULUS_S)) begin
			w_q <= cur_q[VALUE_W-1:0];
		end else if (state_q == S_FILL) begin
			w_q     <= (step_q == '0) ? value_t'(1) : sub_mod(wprev_q, w_q);
			wprev_q <= w_q;
		end
	end
endmodule

`default_nettype wire
